>>> hdl/bfa_pkg.sv
package bfa_pkg;

  // Field widths of the channels and the configuration register.
  localparam int OP_W   = 3;
  localparam int ID_W   = 8;
  localparam int SIZE_W = 40;
  localparam int STAT_W = 3;
  localparam int MAP_W  = 16;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 64;

  // Running position of compaction and free accumulator of the report.
  localparam int POS_W = 50;
  localparam int FR_W  = 51;

  localparam int DEF_MAX_FILES    = 256;
  localparam int DEF_MAX_SEGMENTS = 512;

  localparam logic [SIZE_W-1:0] TOTAL_RESET = 40'd1024;

  // Configuration register addresses.
  localparam logic [CFG_AW-1:0] REG_TOTAL_SIZE = 3'd0;

  // Region grades of the report map.
  localparam logic [1:0] GR_FREE = 2'd0;
  localparam logic [1:0] GR_PART = 2'd1;
  localparam logic [1:0] GR_FULL = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_FORMAT  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_COMPACT = 3'd3,
    OP_REPORT  = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STS_DONE    = 3'd0,
    STS_FULL    = 3'd1,
    STS_IGNORED = 3'd2,
    STS_UNKNOWN = 3'd3,
    STS_REPORT  = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DISP,
    S_SRCH,
    S_SPLIT,
    S_SHUP,
    S_SWEEP,
    S_INS_WR1,
    S_INS_WR2,
    S_CMP,
    S_CMP_TAIL,
    S_INS_CHK,
    S_RM_SLOT,
    S_RM_RB,
    S_RM_RR,
    S_RM_RL,
    S_RM_WB,
    S_RM_WL,
    S_DEL,
    S_REP,
    S_REP_G,
    S_FIN
  } fsm_t;

  // One entry of the segment table.
  typedef struct packed {
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] len;
    logic              used;
    logic [ID_W-1:0]   owner;
  } seg_ent_t;

endpackage

>>> hdl/bfa_if.sv
// Command channel: one allocator command per transfer.
interface bfa_in_if import bfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ID_W-1:0]     file_id;
  logic [SIZE_W-1:0]   req_size;

  modport source (output valid, operation, file_id, req_size, input ready);
  modport sink   (input valid, operation, file_id, req_size, output ready);
endinterface

// Result channel: one status per command.
interface bfa_out_if import bfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [MAP_W-1:0]    segment_map;

  modport source (output valid, status, segment_map, input ready);
  modport sink   (input valid, status, segment_map, output ready);
endinterface

>>> hdl/bfa_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bfa_apb.sv
// Configuration register file behind an APB-style port.
module bfa_apb import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [SIZE_W-1:0] total_size
);

  logic [SIZE_W-1:0] total_r;
  logic [SIZE_W-1:0] total_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_TOTAL_SIZE);

  // Register update on the access phase of a write.
  always_comb begin
    total_nxt = total_r;
    if (wr_en) begin
      total_nxt = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else begin
      total_r <= total_nxt;
    end
  end

  // Read back.
  assign prdata     = (paddr == REG_TOTAL_SIZE) ? CFG_DW'(total_r) : '0;
  assign total_size = total_r;

endmodule

>>> hdl/bfa_core.sv
// Allocator engine: a sequencer that walks the segment table and the
// owner table, both held in RAMs with registered reads.
module bfa_core import bfa_pkg::*; #(
  parameter int MAX_FILES    = DEF_MAX_FILES,
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] total_size,
  bfa_in_if.sink            in_ch,
  bfa_out_if.source         out_ch
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int FW = $clog2(MAX_FILES);
  localparam int FCW = $clog2(MAX_FILES + 1);
  localparam int EW = $bits(seg_ent_t);

  localparam logic [1:0] PH_RD  = 2'd0;
  localparam logic [1:0] PH_USE = 2'd1;
  localparam logic [1:0] PH_ACC = 2'd2;

  // Control state.
  fsm_t               state_r, state_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               latch_r, latch_nxt;
  logic [MAX_FILES-1:0] present_r, present_nxt;
  logic               out_v_r, out_v_nxt;

  // Working registers.
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [SIZE_W-1:0]  req_r, req_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      b_r, b_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic               found_r, found_nxt;
  logic [SIZE_W-1:0]  b_start_r, b_start_nxt;
  logic [SIZE_W-1:0]  b_len_r, b_len_nxt;
  logic               r_free_r, r_free_nxt;
  logic [SIZE_W-1:0]  r_len_r, r_len_nxt;
  logic               l_free_r, l_free_nxt;
  logic [SIZE_W-1:0]  l_start_r, l_start_nxt;
  logic [SIZE_W-1:0]  l_len_r, l_len_nxt;
  logic               pend_r, pend_nxt;
  logic               inc_r, inc_nxt;
  logic [FCW-1:0]     f_r, f_nxt;
  logic               sv_r, sv_nxt;
  logic [FW-1:0]      fd_r, fd_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               tail_free_r, tail_free_nxt;
  logic [SIZE_W-1:0]  tail_start_r, tail_start_nxt;
  logic [SIZE_W-1:0]  tail_len_r, tail_len_nxt;
  logic [2:0]         r_r, r_nxt;
  logic [SIZE_W-4:0]  seg_r, seg_nxt;
  logic [SIZE_W-2:0]  seg3_r, seg3_nxt;
  logic [SIZE_W-1:0]  rs_r, rs_nxt;
  logic [SIZE_W-1:0]  re_r, re_nxt;
  logic [SIZE_W:0]    lo_r, lo_nxt;
  logic [SIZE_W:0]    hi_r, hi_nxt;
  logic               ov_r, ov_nxt;
  logic [FR_W-1:0]    fr_r, fr_nxt;
  logic [MAP_W-1:0]   map_r, map_nxt;
  status_t            status_r, status_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [MAP_W-1:0]   out_map_r, out_map_nxt;

  // RAM ports.
  logic               seg_we;
  logic [AW-1:0]      seg_waddr;
  seg_ent_t           seg_wdata;
  logic [AW-1:0]      seg_raddr;
  logic [EW-1:0]      seg_rdata;
  seg_ent_t           rd;
  logic               own_we;
  logic [FW-1:0]      own_waddr;
  logic [AW-1:0]      own_wdata;
  logic [FW-1:0]      own_raddr;
  logic [AW-1:0]      own_rdata;

  // Helpers.
  logic [CW-1:0]      ip1, im1, bp1, bm1;
  logic               id_ok, own_ok, in_xfer, out_load;
  logic [FW-1:0]      id_idx, own_idx;
  logic [SIZE_W:0]    be, lo_c, hi_c;
  logic [FR_W+1:0]    fr4;
  logic [1:0]         grade;

  bfa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (seg_raddr),
    .rdata (seg_rdata)
  );

  bfa_ram #(.WIDTH(AW), .DEPTH(MAX_FILES)) u_own_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  assign rd      = seg_ent_t'(seg_rdata);
  assign ip1     = i_r + 1'b1;
  assign im1     = i_r - 1'b1;
  assign bp1     = b_r + 1'b1;
  assign bm1     = b_r - 1'b1;
  assign id_ok   = 32'(id_r) < MAX_FILES;
  assign own_ok  = 32'(rd.owner) < MAX_FILES;
  assign id_idx  = FW'(id_r);
  assign own_idx = FW'(rd.owner);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_FIN) && (!out_v_r || out_ch.ready);

  // Overlap of a free segment with the current report region.
  assign be   = {1'b0, rd.start} + {1'b0, rd.len};
  assign lo_c = (rd.start > rs_r) ? {1'b0, rd.start} : {1'b0, rs_r};
  assign hi_c = (be < {1'b0, re_r}) ? be : {1'b0, re_r};

  // Region grade from its free share.
  assign fr4 = {fr_r, 2'b00};
  always_comb begin
    if (seg_r == '0) begin
      grade = GR_FULL;
    end else if (fr4 > (FR_W+2)'(seg3_r)) begin
      grade = GR_FREE;
    end else if (fr4 > (FR_W+2)'(seg_r)) begin
      grade = GR_PART;
    end else begin
      grade = GR_FULL;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.segment_map = out_map_r;

  // Sequencer: next state, RAM accesses and working registers.
  always_comb begin
    state_nxt      = state_r;
    ph_nxt         = ph_r;
    cnt_nxt        = cnt_r;
    latch_nxt      = latch_r;
    present_nxt    = present_r;
    out_v_nxt      = out_v_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    req_nxt        = req_r;
    i_nxt          = i_r;
    n_nxt          = n_r;
    b_nxt          = b_r;
    k_nxt          = k_r;
    found_nxt      = found_r;
    b_start_nxt    = b_start_r;
    b_len_nxt      = b_len_r;
    r_free_nxt     = r_free_r;
    r_len_nxt      = r_len_r;
    l_free_nxt     = l_free_r;
    l_start_nxt    = l_start_r;
    l_len_nxt      = l_len_r;
    pend_nxt       = pend_r;
    inc_nxt        = inc_r;
    f_nxt          = f_r;
    sv_nxt         = sv_r;
    fd_nxt         = fd_r;
    pos_nxt        = pos_r;
    tail_free_nxt  = tail_free_r;
    tail_start_nxt = tail_start_r;
    tail_len_nxt   = tail_len_r;
    r_nxt          = r_r;
    seg_nxt        = seg_r;
    seg3_nxt       = seg3_r;
    rs_nxt         = rs_r;
    re_nxt         = re_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    ov_nxt         = ov_r;
    fr_nxt         = fr_r;
    map_nxt        = map_r;
    status_nxt     = status_r;
    out_status_nxt = out_status_r;
    out_map_nxt    = out_map_r;
    seg_we         = 1'b0;
    seg_waddr      = i_r[AW-1:0];
    seg_wdata      = '0;
    seg_raddr      = i_r[AW-1:0];
    own_we         = 1'b0;
    own_waddr      = '0;
    own_wdata      = '0;
    own_raddr      = '0;

    // The receiver takes the pending result.
    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      // One free span over the default capacity after reset.
      S_INIT: begin
        seg_we    = 1'b1;
        seg_waddr = '0;
        seg_wdata = '{start: '0, len: TOTAL_RESET, used: 1'b0, owner: '0};
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_ch.operation;
          id_nxt    = in_ch.file_id;
          req_nxt   = in_ch.req_size;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        map_nxt = '0;
        ph_nxt  = PH_RD;
        i_nxt   = '0;
        if (op_r == OP_FORMAT) begin
          seg_we      = 1'b1;
          seg_waddr   = '0;
          seg_wdata   = '{start: '0, len: total_size, used: 1'b0, owner: '0};
          cnt_nxt     = CW'(1);
          present_nxt = '0;
          latch_nxt   = 1'b0;
          status_nxt  = STS_DONE;
          state_nxt   = S_FIN;
        end else if (latch_r) begin
          status_nxt = STS_IGNORED;
          state_nxt  = S_FIN;
        end else if (op_r == OP_INSERT) begin
          if (!id_ok) begin
            status_nxt = STS_UNKNOWN;
            state_nxt  = S_FIN;
          end else begin
            found_nxt = 1'b0;
            state_nxt = S_SRCH;
          end
        end else if (op_r == OP_REMOVE) begin
          if (!id_ok || !present_r[id_idx]) begin
            status_nxt = STS_UNKNOWN;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_RM_SLOT;
          end
        end else if (op_r == OP_REPORT) begin
          seg_nxt   = total_size[SIZE_W-1:3];
          seg3_nxt  = {2'b00, total_size[SIZE_W-1:3]} + {1'b0, total_size[SIZE_W-1:3], 1'b0};
          rs_nxt    = '0;
          re_nxt    = SIZE_W'(total_size[SIZE_W-1:3]);
          r_nxt     = '0;
          fr_nxt    = '0;
          state_nxt = S_REP;
        end else begin
          n_nxt         = '0;
          pos_nxt       = '0;
          present_nxt   = '0;
          tail_free_nxt = 1'b0;
          state_nxt     = S_CMP;
        end
      end

      // Best-fit search over the whole table.
      S_SRCH: begin
        if (ph_r == PH_RD) begin
          if (i_r < cnt_r) begin
            seg_raddr = i_r[AW-1:0];
            ph_nxt    = PH_USE;
          end else if (found_r) begin
            state_nxt = S_SPLIT;
          end else begin
            i_nxt         = '0;
            n_nxt         = '0;
            pos_nxt       = '0;
            present_nxt   = '0;
            tail_free_nxt = 1'b0;
            state_nxt     = S_CMP;
          end
        end else begin
          if (!rd.used && rd.len >= req_r && (!found_r || rd.len < b_len_r)) begin
            found_nxt   = 1'b1;
            b_nxt       = i_r;
            b_start_nxt = rd.start;
            b_len_nxt   = rd.len;
          end
          i_nxt  = ip1;
          ph_nxt = PH_RD;
        end
      end

      // Decide whether the chosen span must be split.
      S_SPLIT: begin
        if (b_len_r > req_r) begin
          if (32'(cnt_r) >= MAX_SEGMENTS) begin
            latch_nxt  = 1'b1;
            status_nxt = STS_FULL;
            state_nxt  = S_FIN;
          end else begin
            i_nxt     = cnt_r;
            ph_nxt    = PH_RD;
            state_nxt = S_SHUP;
          end
        end else begin
          state_nxt = S_INS_WR2;
        end
      end

      // Open a hole after the chosen entry, top entry first.
      S_SHUP: begin
        if (ph_r == PH_RD) begin
          if (i_r > bp1) begin
            seg_raddr = im1[AW-1:0];
            ph_nxt    = PH_USE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            k_nxt     = b_r;
            inc_nxt   = 1'b1;
            f_nxt     = '0;
            sv_nxt    = 1'b0;
            state_nxt = S_SWEEP;
          end
        end else begin
          seg_we    = 1'b1;
          seg_waddr = i_r[AW-1:0];
          seg_wdata = rd;
          i_nxt     = im1;
          ph_nxt    = PH_RD;
        end
      end

      // Move owner slots beyond the pivot up or down by one.
      S_SWEEP: begin
        if (sv_r && present_r[fd_r] && CW'(own_rdata) > k_r) begin
          own_we    = 1'b1;
          own_waddr = fd_r;
          own_wdata = inc_r ? own_rdata + 1'b1 : own_rdata - 1'b1;
        end
        if (32'(f_r) < MAX_FILES) begin
          own_raddr = f_r[FW-1:0];
          sv_nxt    = 1'b1;
          fd_nxt    = f_r[FW-1:0];
          f_nxt     = f_r + 1'b1;
        end else begin
          sv_nxt = 1'b0;
          if (!sv_r) begin
            if (op_r == OP_INSERT) begin
              state_nxt = S_INS_WR1;
            end else if (pend_r) begin
              state_nxt = S_RM_WL;
            end else begin
              status_nxt = STS_DONE;
              state_nxt  = S_FIN;
            end
          end
        end
      end

      // Remainder of the split span.
      S_INS_WR1: begin
        seg_we    = 1'b1;
        seg_waddr = bp1[AW-1:0];
        seg_wdata = '{start: b_start_r + req_r, len: b_len_r - req_r,
                      used: 1'b0, owner: '0};
        state_nxt = S_INS_WR2;
      end

      // Claim the chosen entry for the file.
      S_INS_WR2: begin
        seg_we               = 1'b1;
        seg_waddr            = b_r[AW-1:0];
        seg_wdata            = '{start: b_start_r, len: req_r, used: 1'b1, owner: id_r};
        own_we               = 1'b1;
        own_waddr            = id_idx;
        own_wdata            = b_r[AW-1:0];
        present_nxt[id_idx]  = 1'b1;
        status_nxt           = STS_DONE;
        state_nxt            = S_FIN;
      end

      // Pack used entries toward address zero and rebuild the owner map.
      S_CMP: begin
        if (ph_r == PH_RD) begin
          if (i_r < cnt_r) begin
            seg_raddr = i_r[AW-1:0];
            ph_nxt    = PH_USE;
          end else begin
            state_nxt = S_CMP_TAIL;
          end
        end else begin
          if (rd.used) begin
            seg_we    = 1'b1;
            seg_waddr = n_r[AW-1:0];
            seg_wdata = '{start: pos_r[SIZE_W-1:0], len: rd.len, used: 1'b1,
                          owner: rd.owner};
            if (own_ok) begin
              present_nxt[own_idx] = 1'b1;
              own_we               = 1'b1;
              own_waddr            = own_idx;
              own_wdata            = n_r[AW-1:0];
            end
            pos_nxt       = pos_r + POS_W'(rd.len);
            n_nxt         = n_r + 1'b1;
            tail_free_nxt = 1'b0;
          end
          i_nxt  = ip1;
          ph_nxt = PH_RD;
        end
      end

      // Free span at the tail when there is room for it.
      S_CMP_TAIL: begin
        cnt_nxt = n_r;
        if (pos_r < POS_W'(total_size) && 32'(n_r) < MAX_SEGMENTS) begin
          seg_we         = 1'b1;
          seg_waddr      = n_r[AW-1:0];
          seg_wdata      = '{start: pos_r[SIZE_W-1:0],
                             len: total_size - pos_r[SIZE_W-1:0],
                             used: 1'b0, owner: '0};
          cnt_nxt        = n_r + 1'b1;
          tail_free_nxt  = 1'b1;
          tail_start_nxt = pos_r[SIZE_W-1:0];
          tail_len_nxt   = total_size - pos_r[SIZE_W-1:0];
        end
        if (op_r == OP_INSERT) begin
          state_nxt = S_INS_CHK;
        end else begin
          status_nxt = STS_DONE;
          state_nxt  = S_FIN;
        end
      end

      // Retry the insert in the tail span.
      S_INS_CHK: begin
        if (tail_free_r && tail_len_r >= req_r) begin
          b_nxt       = cnt_r - 1'b1;
          b_start_nxt = tail_start_r;
          b_len_nxt   = tail_len_r;
          state_nxt   = S_SPLIT;
        end else begin
          latch_nxt  = 1'b1;
          status_nxt = STS_FULL;
          state_nxt  = S_FIN;
        end
      end

      // Look up the slot of the file to remove.
      S_RM_SLOT: begin
        if (ph_r == PH_RD) begin
          own_raddr = id_idx;
          ph_nxt    = PH_USE;
        end else begin
          present_nxt[id_idx] = 1'b0;
          b_nxt               = CW'(own_rdata);
          ph_nxt              = PH_RD;
          if (CW'(own_rdata) >= cnt_r) begin
            status_nxt = STS_DONE;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_RM_RB;
          end
        end
      end

      S_RM_RB: begin
        if (ph_r == PH_RD) begin
          seg_raddr = b_r[AW-1:0];
          ph_nxt    = PH_USE;
        end else begin
          b_start_nxt = rd.start;
          b_len_nxt   = rd.len;
          ph_nxt      = PH_RD;
          state_nxt   = S_RM_RR;
        end
      end

      // Right neighbor.
      S_RM_RR: begin
        if (ph_r == PH_RD) begin
          if (bp1 < cnt_r) begin
            seg_raddr = bp1[AW-1:0];
            ph_nxt    = PH_USE;
          end else begin
            r_free_nxt = 1'b0;
            state_nxt  = S_RM_RL;
          end
        end else begin
          r_free_nxt = !rd.used;
          r_len_nxt  = rd.len;
          ph_nxt     = PH_RD;
          state_nxt  = S_RM_RL;
        end
      end

      // Left neighbor.
      S_RM_RL: begin
        if (ph_r == PH_RD) begin
          if (b_r != '0) begin
            seg_raddr = bm1[AW-1:0];
            ph_nxt    = PH_USE;
          end else begin
            l_free_nxt = 1'b0;
            state_nxt  = S_RM_WB;
          end
        end else begin
          l_free_nxt  = !rd.used;
          l_start_nxt = rd.start;
          l_len_nxt   = rd.len;
          ph_nxt      = PH_RD;
          state_nxt   = S_RM_WB;
        end
      end

      // Free the entry, absorbing a free right neighbor.
      S_RM_WB: begin
        seg_we    = 1'b1;
        seg_waddr = b_r[AW-1:0];
        seg_wdata = '{start: b_start_r,
                      len: r_free_r ? b_len_r + r_len_r : b_len_r,
                      used: 1'b0, owner: '0};
        b_len_nxt = r_free_r ? b_len_r + r_len_r : b_len_r;
        pend_nxt  = l_free_r;
        if (r_free_r) begin
          k_nxt     = bp1;
          i_nxt     = bp1;
          state_nxt = S_DEL;
        end else if (l_free_r) begin
          state_nxt = S_RM_WL;
        end else begin
          status_nxt = STS_DONE;
          state_nxt  = S_FIN;
        end
      end

      // Merge into a free left neighbor.
      S_RM_WL: begin
        seg_we    = 1'b1;
        seg_waddr = bm1[AW-1:0];
        seg_wdata = '{start: l_start_r, len: l_len_r + b_len_r, used: 1'b0, owner: '0};
        pend_nxt  = 1'b0;
        k_nxt     = b_r;
        i_nxt     = b_r;
        ph_nxt    = PH_RD;
        state_nxt = S_DEL;
      end

      // Close the gap left by a deleted entry.
      S_DEL: begin
        if (ph_r == PH_RD) begin
          if (ip1 < cnt_r) begin
            seg_raddr = ip1[AW-1:0];
            ph_nxt    = PH_USE;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            inc_nxt   = 1'b0;
            f_nxt     = '0;
            sv_nxt    = 1'b0;
            state_nxt = S_SWEEP;
          end
        end else begin
          seg_we    = 1'b1;
          seg_waddr = i_r[AW-1:0];
          seg_wdata = rd;
          i_nxt     = ip1;
          ph_nxt    = PH_RD;
        end
      end

      // Free units of one region: read, clip, accumulate.
      S_REP: begin
        case (ph_r)
          PH_RD: begin
            if (i_r < cnt_r) begin
              seg_raddr = i_r[AW-1:0];
              ph_nxt    = PH_USE;
            end else begin
              state_nxt = S_REP_G;
            end
          end
          PH_USE: begin
            lo_nxt = lo_c;
            hi_nxt = hi_c;
            ov_nxt = !rd.used;
            ph_nxt = PH_ACC;
          end
          default: begin
            if (ov_r && hi_r > lo_r) begin
              fr_nxt = fr_r + FR_W'(hi_r - lo_r);
            end
            i_nxt  = ip1;
            ph_nxt = PH_RD;
          end
        endcase
      end

      S_REP_G: begin
        map_nxt[{r_r, 1'b0} +: 2] = grade;
        if (&r_r) begin
          status_nxt = STS_REPORT;
          state_nxt  = S_FIN;
        end else begin
          r_nxt     = r_r + 1'b1;
          rs_nxt    = re_r;
          re_nxt    = re_r + SIZE_W'(seg_r);
          fr_nxt    = '0;
          i_nxt     = '0;
          ph_nxt    = PH_RD;
          state_nxt = S_REP;
        end
      end

      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (out_load) begin
          out_v_nxt      = 1'b1;
          out_status_nxt = status_r;
          out_map_nxt    = map_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      ph_r      <= PH_RD;
      cnt_r     <= CW'(1);
      latch_r   <= 1'b0;
      present_r <= '0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ph_r      <= ph_nxt;
      cnt_r     <= cnt_nxt;
      latch_r   <= latch_nxt;
      present_r <= present_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    req_r        <= req_nxt;
    i_r          <= i_nxt;
    n_r          <= n_nxt;
    b_r          <= b_nxt;
    k_r          <= k_nxt;
    found_r      <= found_nxt;
    b_start_r    <= b_start_nxt;
    b_len_r      <= b_len_nxt;
    r_free_r     <= r_free_nxt;
    r_len_r      <= r_len_nxt;
    l_free_r     <= l_free_nxt;
    l_start_r    <= l_start_nxt;
    l_len_r      <= l_len_nxt;
    pend_r       <= pend_nxt;
    inc_r        <= inc_nxt;
    f_r          <= f_nxt;
    sv_r         <= sv_nxt;
    fd_r         <= fd_nxt;
    pos_r        <= pos_nxt;
    tail_free_r  <= tail_free_nxt;
    tail_start_r <= tail_start_nxt;
    tail_len_r   <= tail_len_nxt;
    r_r          <= r_nxt;
    seg_r        <= seg_nxt;
    seg3_r       <= seg3_nxt;
    rs_r         <= rs_nxt;
    re_r         <= re_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    ov_r         <= ov_nxt;
    fr_r         <= fr_nxt;
    map_r        <= map_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_map_r    <= out_map_nxt;
  end

  // The table never holds more entries than the RAM.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_SEGMENTS)
    else $error("segment count exceeds table depth");

  // An ignored command is only reported while disk full is latched.
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && status_r == STS_IGNORED) |-> latch_r)
    else $error("ignored status without disk full latch");

  // Only a report carries a region map.
  a_map: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != STS_REPORT) |-> (out_ch.segment_map == '0))
    else $error("region map on a non-report result");

  // The owner sweep touches only the owner table.
  a_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> !seg_we)
    else $error("segment table written during owner sweep");

  // An accepted command is decoded in the next cycle.
  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_DISP))
    else $error("accepted command not decoded");

endmodule

>>> hdl/best_fit_allocator_with_compaction_unit.sv
// Best-fit disk space allocator with compaction.
// Commands arrive on in_ch (operation, file_id, req_size) and each one
// produces exactly one result on out_ch (status, segment_map). A transfer
// takes place when valid and ready are both high. The block works on one
// command at a time; in_ch.ready is high only while it waits for a command.
// Work per command, with N table entries and F = MAX_FILES:
//   format, rejected or ignored commands: no table walk;
//   insert: a search over N entries, a compaction when no span fits,
//   and for a split a shift of entries and a sweep of F owner slots;
//   remove: a slot lookup, neighbor reads, and a shift and a sweep
//   for each merge; compact: one pass over N; report: a pass over N for each of 8 regions.
// The walks run over the segment RAM, which has one read port, one write
// port and a registered read.
// The total_size register sits behind the APB port at byte address 0.
// After reset the block first writes the initial free span of
// 1024 units before in_ch.ready rises. A result waits in the output
// register while out_ch.ready is low; the next command is accepted
// meanwhile, and its result is held back until the register is free.
module best_fit_allocator_with_compaction_unit import bfa_pkg::*; #(
  parameter int MAX_FILES    = DEF_MAX_FILES,
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic              clk,
  input  logic              rst_n,
  bfa_in_if.sink            in_ch,
  bfa_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [SIZE_W-1:0] total_size;

  // Configuration registers.
  bfa_apb u_apb (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .total_size (total_size)
  );

  // Allocation engine with its table memories.
  bfa_core #(
    .MAX_FILES    (MAX_FILES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .total_size (total_size),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

endmodule
